// ===== sv/vrn_pkg.sv =====
// vrn_pkg: shared types and widths for the vector renormalize block.
// No dependencies.
`timescale 1ns / 1ps
package vrn_pkg;
    localparam int unsigned FieldW     = 24;
    localparam int unsigned MaxComps   = 4;
    localparam int unsigned SumW       = 50;
    localparam int unsigned RootW      = 25;
    localparam int unsigned ProdW      = 47;
    localparam int unsigned DefComps   = 3;
    localparam logic [FieldW-1:0] TargetReset = 24'd65536;
    localparam logic [FieldW-1:0] MaxPos      = 24'h7FFFFF;
    localparam logic [FieldW-1:0] MaxNeg      = 24'h800000;

    typedef struct packed {
        logic signed [FieldW-1:0] comp_3;
        logic signed [FieldW-1:0] comp_2;
        logic signed [FieldW-1:0] comp_1;
        logic signed [FieldW-1:0] comp_0;
    } t_vec_in;

    typedef struct packed {
        logic signed [FieldW-1:0] out_0;
        logic signed [FieldW-1:0] out_1;
        logic signed [FieldW-1:0] out_2;
        logic signed [FieldW-1:0] out_3;
        logic                     zero_vector;
        logic                     saturated;
    } t_vec_out;
endpackage

// ===== sv/vrn_div.sv =====
// vrn_div: pipelined restoring divider, one quotient bit per stage.
// Depends on vrn_pkg.
`timescale 1ns / 1ps
module vrn_div
    import vrn_pkg::*;
#(
    parameter int unsigned NW = ProdW,
    parameter int unsigned DW = RootW,
    parameter int unsigned TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [NW-1:0] o_quot,
    output logic [TW-1:0] o_tag
);
    logic [DW:0]   r_rem [NW];
    logic [NW-1:0] r_num [NW];
    logic [DW-1:0] r_den [NW];
    logic [TW-1:0] r_tag [NW];
    logic [NW-1:0] r_vld;

    for (genvar s = 0; s < NW; s++) begin : g_st
        logic [DW:0]   c_rem;
        logic [NW-1:0] c_num;
        logic [DW-1:0] c_den;
        logic [TW-1:0] c_tag;
        logic          c_vld;
        logic [DW+1:0] n_sh;
        logic [DW+1:0] n_df;
        if (s == 0) begin : g_head
            assign c_rem = '0;
            assign c_num = i_num;
            assign c_den = i_den;
            assign c_tag = i_tag;
            assign c_vld = i_valid;
        end else begin : g_body
            assign c_rem = r_rem[s-1];
            assign c_num = r_num[s-1];
            assign c_den = r_den[s-1];
            assign c_tag = r_tag[s-1];
            assign c_vld = r_vld[s-1];
        end
        always_comb begin
            n_sh = {c_rem, c_num[NW-1]};
            n_df = n_sh - {2'b00, c_den};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= c_vld;
            end
            if (i_en) begin
                r_rem[s] <= n_df[DW+1] ? n_sh[DW:0] : n_df[DW:0];
                r_num[s] <= {c_num[NW-2:0], ~n_df[DW+1]};
                r_den[s] <= c_den;
                r_tag[s] <= c_tag;
            end
        end
    end

    assign o_valid = r_vld[NW-1];
    assign o_quot  = r_num[NW-1];
    assign o_tag   = r_tag[NW-1];
endmodule

// ===== sv/vector_renormalize_top.sv =====
// vector_renormalize_top: scales a vector to a programmable magnitude.
// Depends on vrn_pkg and vrn_div.
`timescale 1ns / 1ps
// Usage
//   Input channel (i_valid/o_stall, payload i_vec) carries one vector request
//   of signed Q8.16 components. Output channel (o_valid/i_stall, o_res)
//   returns the scaled vector plus zero_vector and saturated flags.
//   i_cfg_we writes target_norm (unsigned Q8.16); the user must do so only
//   while the block is idle, which the block does not enforce. Throughput:
//   one request per cycle while o_stall is low, via the square-root pipeline
//   (one result bit per stage) and the divider (one quotient bit per stage).
// Stall: the whole pipeline freezes while the output register holds a
//   result and i_stall is high; o_stall then goes high. No request is lost
//   or repeated. Every stage holds, empty ones included, until the held
//   result is taken.
// Reset: synchronous active-low i_rst_n clears all valid bits and sets
//   target_norm to 1.0.
module vector_renormalize_top
    import vrn_pkg::*;
#(
    parameter int unsigned COMPONENTS = DefComps
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_vec_in  i_vec,
    output logic     o_valid,
    input  logic     i_stall,
    output t_vec_out o_res,
    input  logic              i_cfg_we,
    input  logic [FieldW-1:0] i_cfg_data
);
    localparam int unsigned SqS = RootW;        // sqrt stages

    logic [FieldW-1:0] r_target;
    logic              en;

    // Advance whenever output register is free or being drained.
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_target <= TargetReset;
        else if (i_cfg_we) r_target <= i_cfg_data;
    end

    // Stage 1: magnitudes, signs and squares.
    logic [FieldW-1:0] n_mag [MaxComps];
    logic [MaxComps-1:0] n_neg;
    logic [FieldW-1:0] r1_mag [MaxComps];
    logic [MaxComps-1:0] r1_neg;
    logic [2*FieldW-1:0] r1_sq [MaxComps];
    logic r1_vld;
    logic signed [FieldW-1:0] in_c [MaxComps];
    assign in_c[0] = i_vec.comp_0;
    assign in_c[1] = i_vec.comp_1;
    assign in_c[2] = i_vec.comp_2;
    assign in_c[3] = i_vec.comp_3;

    always_comb begin
        for (int k = 0; k < MaxComps; k++) begin
            n_neg[k] = in_c[k][FieldW-1] && (k < COMPONENTS);
            n_mag[k] = (k >= COMPONENTS) ? '0 :
                       (n_neg[k] ? FieldW'(-in_c[k]) : in_c[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else if (en) r1_vld <= i_valid;
        if (en) begin
            for (int k = 0; k < MaxComps; k++) begin
                r1_mag[k] <= n_mag[k];
                r1_sq[k]  <= n_mag[k] * n_mag[k];
            end
            r1_neg <= n_neg;
        end
    end

    // Stage 2: sum of squares.
    logic [SumW-1:0] r2_sum;
    logic [FieldW-1:0] r2_mag [MaxComps];
    logic [MaxComps-1:0] r2_neg;
    logic r2_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else if (en) r2_vld <= r1_vld;
        if (en) begin
            r2_sum <= SumW'(r1_sq[0]) + SumW'(r1_sq[1]) + SumW'(r1_sq[2])
                    + SumW'(r1_sq[3]);
            r2_mag <= r1_mag;
            r2_neg <= r1_neg;
        end
    end

    // Square root: one result bit per stage, restoring method.
    logic [SumW-1:0]  s_x   [SqS];
    logic [RootW-1:0] s_r   [SqS];
    logic [RootW+1:0] s_rem [SqS];
    logic [FieldW-1:0] s_mag [SqS][MaxComps];
    logic [MaxComps-1:0] s_neg [SqS];
    logic [SqS-1:0] s_vld;

    for (genvar s = 0; s < SqS; s++) begin : g_sq
        logic [SumW-1:0]     c_x;
        logic [RootW-1:0]    c_r;
        logic [RootW+1:0]    c_rem;
        logic [FieldW-1:0]   c_mag [MaxComps];
        logic [MaxComps-1:0] c_neg;
        logic                c_vld;
        logic [RootW+1:0] n_rem, n_trial;
        if (s == 0) begin : g_head
            assign c_x   = r2_sum;
            assign c_r   = '0;
            assign c_rem = '0;
            assign c_neg = r2_neg;
            assign c_vld = r2_vld;
            always_comb begin
                for (int k = 0; k < MaxComps; k++) c_mag[k] = r2_mag[k];
            end
        end else begin : g_body
            assign c_x   = s_x[s-1];
            assign c_r   = s_r[s-1];
            assign c_rem = s_rem[s-1];
            assign c_neg = s_neg[s-1];
            assign c_vld = s_vld[s-1];
            always_comb begin
                for (int k = 0; k < MaxComps; k++) c_mag[k] = s_mag[s-1][k];
            end
        end
        always_comb begin
            n_rem   = {c_rem[RootW-1:0], c_x[SumW-1 -: 2]};
            n_trial = n_rem - {c_r, 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) s_vld[s] <= 1'b0;
            else if (en) s_vld[s] <= c_vld;
            if (en) begin
                s_x[s]   <= {c_x[SumW-3:0], 2'b00};
                s_rem[s] <= n_trial[RootW+1] ? n_rem : n_trial;
                s_r[s]   <= {c_r[RootW-2:0], ~n_trial[RootW+1]};
                for (int k = 0; k < MaxComps; k++) s_mag[s][k] <= c_mag[k];
                s_neg[s] <= c_neg;
            end
        end
    end

    // Products, one per lane, each lane with its own divider pipeline.
    logic [ProdW-1:0] r3_prod [MaxComps];
    logic [RootW-1:0] r3_norm;
    logic [MaxComps-1:0] r3_neg;
    logic r3_zero, r3_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else if (en) r3_vld <= s_vld[SqS-1];
        if (en) begin
            for (int k = 0; k < MaxComps; k++)
                r3_prod[k] <= ProdW'(s_mag[SqS-1][k] * r_target);
            r3_norm <= s_r[SqS-1];
            r3_neg  <= s_neg[SqS-1];
            r3_zero <= (s_r[SqS-1] == '0);
        end
    end

    logic [ProdW-1:0] d_quot [MaxComps];
    logic [MaxComps-1:0] d_vld;
    logic [MaxComps:0]   d_tag [MaxComps];
    for (genvar k = 0; k < MaxComps; k++) begin : g_div
        vrn_div #(.NW(ProdW), .DW(RootW), .TW(MaxComps + 1)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (r3_vld),
            .i_num   (r3_prod[k]),
            .i_den   (r3_zero ? RootW'(1) : r3_norm),
            .i_tag   ({r3_zero, r3_neg}),
            .o_valid (d_vld[k]),
            .o_quot  (d_quot[k]),
            .o_tag   (d_tag[k])
        );
    end

    // Saturate, negate, register output.
    logic [FieldW-1:0] n_o [MaxComps];
    logic [MaxComps-1:0] n_sat;
    logic n_zero;
    always_comb begin
        n_zero = d_tag[0][MaxComps];
        for (int k = 0; k < MaxComps; k++) begin
            n_sat[k] = 1'b0;
            n_o[k]   = '0;
            if (!n_zero && k < COMPONENTS) begin
                if (d_tag[0][k]) begin
                    n_sat[k] = d_quot[k] > ProdW'(MaxNeg);
                    n_o[k] = n_sat[k] ? MaxNeg : FieldW'(-d_quot[k]);
                end else begin
                    n_sat[k] = d_quot[k] > ProdW'(MaxPos);
                    n_o[k] = n_sat[k] ? MaxPos : d_quot[k][FieldW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (en) o_valid <= d_vld[0];
        if (en) begin
            o_res.out_0 <= n_o[0];
            o_res.out_1 <= n_o[1];
            o_res.out_2 <= n_o[2];
            o_res.out_3 <= n_o[3];
            o_res.zero_vector <= n_zero;
            o_res.saturated   <= |n_sat;
        end
    end

    // Lanes other than lane 0 carry copies of the valid and tag bits.
    logic unused_tw;
    always_comb begin
        unused_tw = 1'b0;
        for (int k = 1; k < MaxComps; k++)
            unused_tw = unused_tw | d_vld[k] | (|d_tag[k]);
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.zero_vector |-> !o_res.saturated)
        else $error("zero vector flagged saturated");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res))
        else $error("held result changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("stall without held result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_vld[0] == d_vld[MaxComps-1])
        else $error("divider lanes out of step");
endmodule

// ===== verif/tb_vector_renormalize_top.sv =====
// tb_vector_renormalize_top: self-checking testbench for vector_renormalize_top.
// Depends on vrn_pkg and the vector_renormalize_top RTL; needs no input files.
`timescale 1ns / 1ps

// Holds the expected renormalized vectors and checks the block's results.
class renorm_scoreboard;
    vrn_pkg::t_vec_out pending_q[$];
    logic [23:0] target;
    int comps;
    int errors;
    int checked;
    int sat_seen;
    int zero_seen;

    function void note_request(vrn_pkg::t_vec_in v);
        logic signed [23:0] c [4];
        logic [23:0] q [4];
        logic [49:0] sum;
        logic [49:0] rem;
        logic [49:0] root;
        logic [49:0] bitv;
        logic [47:0] mag;
        logic [47:0] quo;
        vrn_pkg::t_vec_out r;
        logic sat;
        c[0] = v.comp_0;
        c[1] = v.comp_1;
        c[2] = v.comp_2;
        c[3] = v.comp_3;
        r = '0;
        sum = '0;
        sat = 1'b0;
        for (int i = 0; i < comps; i++) begin
            mag = (c[i] < 0) ? 48'(-49'(c[i])) : 48'(c[i]);
            sum += 50'(mag * mag);
        end
        if (sum == 0) begin
            r.zero_vector = 1'b1;
        end else begin
            // floor square root, one result bit per pass
            rem = sum;
            root = '0;
            bitv = 50'd1 << 48;
            while (bitv > rem) bitv >>= 2;
            while (bitv != 0) begin
                if (rem >= root + bitv) begin
                    rem -= root + bitv;
                    root = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            for (int i = 0; i < 4; i++) begin
                q[i] = '0;
                if (i < comps) begin
                    mag = (c[i] < 0) ? 48'(-49'(c[i])) : 48'(c[i]);
                    quo = (mag * 48'(target)) / 48'(root);
                    if (c[i] < 0) begin
                        if (quo > 48'd8388608) begin
                            quo = 48'd8388608;
                            sat = 1'b1;
                        end
                        q[i] = 24'(-quo);
                    end else begin
                        if (quo > 48'd8388607) begin
                            quo = 48'd8388607;
                            sat = 1'b1;
                        end
                        q[i] = quo[23:0];
                    end
                end
            end
            r.out_0 = q[0];
            r.out_1 = q[1];
            r.out_2 = q[2];
            r.out_3 = q[3];
            r.saturated = sat;
        end
        pending_q = {pending_q, r};
    endfunction

    function void check_result(vrn_pkg::t_vec_out got);
        vrn_pkg::t_vec_out exp_r;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected result %h", $realtime, got);
            errors++;
            return;
        end
        exp_r = pending_q.pop_front();
        checked++;
        if (got.saturated) sat_seen++;
        if (got.zero_vector) zero_seen++;
        if (got.out_0 !== exp_r.out_0)
            $display("%0t: out_0 exp %h got %h", $realtime, exp_r.out_0, got.out_0);
        if (got.out_1 !== exp_r.out_1)
            $display("%0t: out_1 exp %h got %h", $realtime, exp_r.out_1, got.out_1);
        if (got.out_2 !== exp_r.out_2)
            $display("%0t: out_2 exp %h got %h", $realtime, exp_r.out_2, got.out_2);
        if (got.out_3 !== exp_r.out_3)
            $display("%0t: out_3 exp %h got %h", $realtime, exp_r.out_3, got.out_3);
        if (got.zero_vector !== exp_r.zero_vector)
            $display("%0t: zero_vector exp %b got %b", $realtime,
                     exp_r.zero_vector, got.zero_vector);
        if (got.saturated !== exp_r.saturated)
            $display("%0t: saturated exp %b got %b", $realtime,
                     exp_r.saturated, got.saturated);
        if (got !== exp_r) errors++;
    endfunction
endclass

module tb_vector_renormalize_top;
    import vrn_pkg::*;

    localparam int Comps = DefComps;
    localparam int Latency = 76;
    localparam int CycleLimit = 600000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_vec_in i_vec;
    logic o_valid;
    logic i_stall;
    t_vec_out o_res;
    logic i_cfg_we;
    logic [FieldW-1:0] i_cfg_data;

    renorm_scoreboard sb;
    int cycle_count = 0;
    int sent;
    bit long_hold;      // set by the sender to request a long receiver hold-off
    bit rx_free;        // receiver never stalls while set

    vector_renormalize_top #(.COMPONENTS(Comps)) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_vec(i_vec),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_res(o_res),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Check every accepted result; sample at the edge, before the drivers update.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_res);
    end

    // Receiver: random stall pattern, quiet stretches, and one long hold-off.
    initial begin : receiver
        int mode;
        logic hold;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                long_hold = 1'b0;
            end
            mode = $urandom_range(0, 3);
            for (int k = $urandom_range(5, 60); k > 0; k--) begin
                case (mode)
                    0: hold = 1'b0;
                    1: hold = ($urandom_range(0, 3) == 0);
                    2: hold = ($urandom_range(0, 1) == 0);
                    default: hold = ($urandom_range(0, 7) != 0);
                endcase
                i_stall <= hold && !rx_free;
                @(posedge i_clk);
            end
        end
    end

    function automatic logic [23:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 15)) - 24'd8;
            3: return 24'($urandom_range(0, 2047)) - 24'd1024;
            default: return 24'($urandom);
        endcase
    endfunction

    // Offer one request and hold it until accepted.
    task automatic send_vec(logic [23:0] c0, logic [23:0] c1, logic [23:0] c2,
                            logic [23:0] c3);
        t_vec_in v;
        v.comp_0 = c0;
        v.comp_1 = c1;
        v.comp_2 = c2;
        v.comp_3 = c3;
        i_valid <= 1'b1;
        i_vec <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(v);
        sent++;
    endtask

    task automatic idle_cycles(int n);
        i_valid <= 1'b0;
        i_vec <= t_vec_in'({$urandom, $urandom, $urandom});
        repeat (n) @(posedge i_clk);
    endtask

    // Drain all outstanding results, then let the pipeline settle.
    task automatic drain();
        i_valid <= 1'b0;
        rx_free = 1'b1;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
        rx_free = 1'b0;
    endtask

    task automatic write_target(logic [23:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.target = value;
    endtask

    task automatic random_burst(int count);
        int n;
        n = 0;
        while (n < count) begin
            for (int k = $urandom_range(1, 40); k > 0 && n < count; k--) begin
                send_vec(rand_comp(), rand_comp(), rand_comp(), rand_comp());
                n++;
            end
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
        end
        i_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [23:0] targets [6];
        targets = '{24'd65536, 24'hFFFFFF, 24'd0, 24'd1, 24'd32768, 24'd300000};
        sb = new();
        sb.comps = Comps;
        sb.target = TargetReset;
        sent = 0;
        long_hold = 1'b0;
        rx_free = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_vec = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset target, extremes, zero vector, unused lane, saturation.
        send_vec(24'h0, 24'h0, 24'h0, 24'h0);
        send_vec(24'h0, 24'h0, 24'h0, 24'h7FFFFF);
        send_vec(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_vec(24'h800000, 24'h800000, 24'h800000, 24'h800000);
        send_vec(24'h000001, 24'h0, 24'h0, 24'h0);
        send_vec(24'hFFFFFF, 24'h0, 24'h0, 24'h0);
        send_vec(24'h010000, 24'hFF0000, 24'h000001, 24'h123456);
        send_vec(24'h7FFFFF, 24'h000001, 24'h800000, 24'h0);
        drain();
        write_target(24'hFFFFFF);
        send_vec(24'h000001, 24'h0, 24'h0, 24'h0);       // clamps high
        send_vec(24'hFFFFFF, 24'h0, 24'h0, 24'h0);       // clamps low
        send_vec(24'h000001, 24'hFFFFFF, 24'h000001, 24'h0);
        send_vec(24'h7FFFFF, 24'h800000, 24'h0, 24'h0);
        send_vec(24'h0, 24'h0, 24'h0, 24'h800000);
        drain();
        write_target(24'd0);
        send_vec(24'h7FFFFF, 24'h800000, 24'h000003, 24'h0);
        send_vec(24'h0, 24'h0, 24'h0, 24'h0);
        drain();

        // Fill the pipeline against a long receiver hold-off.
        write_target(TargetReset);
        long_hold = 1'b1;
        random_burst(150);
        drain();

        // Random phases across target settings, extremes included.
        for (int p = 0; p < 6; p++) begin
            write_target(targets[p]);
            random_burst(265);
            drain();
        end

        $display("covered %0d requests, %0d checked, %0d saturated, %0d zero vectors",
                 sent, sb.checked, sb.sat_seen, sb.zero_seen);
        $display("targets swept from 0 to full scale with random stall and gap patterns");
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("vector_renormalize_top regression: pass");
        end else begin
            $display("vector_renormalize_top regression: fail");
        end
        $finish;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        if (cycle_count > CycleLimit) begin
            $display("timeout at cycle %0d", cycle_count);
            $display("vector_renormalize_top regression: fail");
            $finish;
        end
    end
endmodule
